// File: sv/bsm_pkg.sv
// bsm_pkg: shared widths, stage record and booth recoding codes for the booth multiplier
// used by bsm_cell and booth_signed_multiplier_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

  // operand width used by the recoding; operand ports stay 32 bits wide
  localparam int OP_W   = 32;
  // accumulator carries one guard bit so the most negative multiplicand is exact
  localparam int ACC_W  = OP_W + 1;
  localparam int IN_W   = 32;
  localparam int PROD_W = 64;

  // recoded action for one multiplier bit pair
  typedef enum logic [1:0] {
    BOOTH_NONE,
    BOOTH_ADD,
    BOOTH_SUB
  } booth_op_t;

  // bit pair {q0, q1} as seen by one cell
  localparam logic [1:0] PAIR_SUB = 2'b10;
  localparam logic [1:0] PAIR_ADD = 2'b01;

  // everything one request carries from cell to cell
  typedef struct packed {
    logic                    valid;
    logic signed [ACC_W-1:0] acc;
    logic        [OP_W-1:0]  q;
    logic                    q1;
    logic signed [ACC_W-1:0] mcand;
  } bsm_stage_t;

endpackage

`default_nettype wire

// File: sv/bsm_cell.sv
// bsm_cell: one radix-2 booth step (add or subtract, then arithmetic shift) with its register
// depends on bsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsm_cell import bsm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  bsm_stage_t stage_i,
  output bsm_stage_t stage_o
);

  booth_op_t               op;
  logic        [1:0]       pair;
  logic signed [ACC_W-1:0] sum;
  bsm_stage_t              stage_nxt;
  bsm_stage_t              stage_r;

  // recode the low multiplier bit and the bit shifted out last step
  always_comb begin
    pair = {stage_i.q[0], stage_i.q1};
    case (pair)
      PAIR_SUB: op = BOOTH_SUB;
      PAIR_ADD: op = BOOTH_ADD;
      default:  op = BOOTH_NONE;
    endcase
  end

  // add or subtract the multiplicand into the upper half
  always_comb begin
    case (op)
      BOOTH_ADD: sum = stage_i.acc + stage_i.mcand;
      BOOTH_SUB: sum = stage_i.acc - stage_i.mcand;
      default:   sum = stage_i.acc;
    endcase
  end

  // arithmetic shift of the combined accumulator and multiplier
  always_comb begin
    stage_nxt.valid = stage_i.valid;
    stage_nxt.acc   = {sum[ACC_W-1], sum[ACC_W-1:1]};
    stage_nxt.q     = {sum[0], stage_i.q[OP_W-1:1]};
    stage_nxt.q1    = stage_i.q[0];
    stage_nxt.mcand = stage_i.mcand;
  end

  // valid flag is reset, payload follows the pipeline enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

`default_nettype wire

// File: sv/booth_signed_multiplier_top.sv
// booth_signed_multiplier_top: signed radix-2 booth multiplier as a chain of step cells
// depends on bsm_pkg and bsm_cell
//
//   channel   direction  ports                                   meaning
//   in_       in         in_valid, in_stall, in_multiplicand,    one operand pair per request
//                        in_multiplier
//   out_      out        out_valid, out_stall, out_product       signed 64-bit product
//
// one request accepted per cycle while in_stall is low; each result passes through the register
// of every booth cell in the chain.
// the last cell's register is the output register; while out_stall holds a waiting
// result the whole chain freezes and in_stall is raised.
// reset (synchronous, rst_n low) clears the valid flag of every cell.
`timescale 1ns / 1ps
`default_nettype none

module booth_signed_multiplier_top import bsm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [IN_W-1:0]   in_multiplicand,
  input  logic signed [IN_W-1:0]   in_multiplier,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [PROD_W-1:0] out_product
);

  bsm_stage_t chain [OP_W+1];
  logic       adv;

  // chain moves unless a finished result is held back
  assign adv      = !(chain[OP_W].valid && out_stall);
  assign in_stall = !adv;

  // initial stage record: zero accumulator, sign-extended multiplicand
  always_comb begin
    chain[0].valid = in_valid;
    chain[0].acc   = '0;
    chain[0].q     = in_multiplier[OP_W-1:0];
    chain[0].q1    = 1'b0;
    chain[0].mcand = ACC_W'($signed(in_multiplicand[OP_W-1:0]));
  end

  // one cell per booth step
  for (genvar i = 0; i < OP_W; i++) begin : g_cell
    bsm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  // product is the combined accumulator and multiplier, truncated to its low PROD_W bits
  assign out_valid   = chain[OP_W].valid;
  assign out_product = PROD_W'($signed({chain[OP_W].acc, chain[OP_W].q}));

endmodule

`default_nettype wire
